>>> rtl/utx_pkg.sv
// Shared types and constants for the 8N1 serial transmitter.
package utx_pkg;

  // Word kinds carried on the input tuser bit.
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned OUT_W    = 8;

  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd1666;

  // One classified word as it sits in the queue between front and back.
  typedef struct packed {
    logic              is_load;
    logic [BYTE_W-1:0] data;
  } utx_cmd_t;

  // Queue head presented to the back end.
  typedef struct packed {
    logic     valid;
    utx_cmd_t cmd;
  } utx_head_t;

endpackage

>>> rtl/utx_front.sv
// Front end: accepts input words, classifies them and holds them in a short queue.
module utx_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [utx_pkg::BYTE_W-1:0]    in_tdata,
  input  logic                          in_tuser,
  output utx_pkg::utx_head_t            head,
  input  logic                          pop
);
  import utx_pkg::*;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  utx_cmd_t           q_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push, pop_ok;
  utx_cmd_t           cmd_in;

  assign in_tready = (count_r != CNT_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop_ok    = pop && (count_r != '0);

  always_comb begin
    cmd_in.is_load = (in_tuser == KIND_LOAD);
    cmd_in.data    = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = push   ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop_ok ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop_ok) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop_ok && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  always_comb begin
    head.valid = (count_r != '0);
    head.cmd   = q_r[rd_ptr_r];
  end

endmodule

>>> rtl/utx_back.sv
// Back end: bit timer, frame sequencer and registered result stage.
module utx_back #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wen,
  input  logic [utx_pkg::PERIOD_W-1:0]   cfg_wdata,
  input  utx_pkg::utx_head_t             head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [utx_pkg::OUT_W-1:0]      out_tdata
);
  import utx_pkg::*;

  localparam int unsigned IDX_W = $clog2(DATA_BITS + 3);
  localparam logic [IDX_W-1:0] LAST_DATA = IDX_W'(DATA_BITS);
  localparam logic [IDX_W-1:0] STOP_IDX  = IDX_W'(DATA_BITS + 1);

  logic [PERIOD_W-1:0]  period_r;
  logic [DATA_BITS-1:0] shift_r, shift_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt, idx_inc;
  logic [PERIOD_W-1:0]  ticks_r, ticks_nxt;
  logic                 sending_r, sending_nxt;
  logic                 line_r, line_nxt;
  logic                 dropped;
  logic                 ovalid_r;
  logic [2:0]           ores_r;
  logic [DATA_BITS+BYTE_W-1:0] load_ext;

  // The output stage takes a new result when empty or being drained.
  assign pop      = head.valid && (!ovalid_r || out_tready);
  assign idx_inc  = IDX_W'(idx_r + 1'b1);
  assign load_ext = {{DATA_BITS{1'b0}}, head.cmd.data};

  always_comb begin
    shift_nxt   = shift_r;
    idx_nxt     = idx_r;
    ticks_nxt   = ticks_r;
    sending_nxt = sending_r;
    line_nxt    = line_r;
    dropped     = 1'b0;
    if (head.cmd.is_load) begin
      if (sending_r) begin
        dropped = 1'b1;
      end else begin
        shift_nxt   = load_ext[DATA_BITS-1:0];
        idx_nxt     = '0;
        ticks_nxt   = '0;
        sending_nxt = 1'b1;
        line_nxt    = 1'b0;
      end
    end else if (sending_r) begin
      if (ticks_r >= period_r) begin
        ticks_nxt = '0;
        idx_nxt   = idx_inc;
        if (idx_inc <= LAST_DATA) begin
          line_nxt  = shift_r[0];
          shift_nxt = shift_r >> 1;
        end else if (idx_inc == STOP_IDX) begin
          line_nxt = 1'b1;
        end else begin
          sending_nxt = 1'b0;
          idx_nxt     = '0;
          line_nxt    = 1'b1;
        end
      end else begin
        ticks_nxt = PERIOD_W'(ticks_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= BIT_PERIOD_RST;
      shift_r   <= '0;
      idx_r     <= '0;
      ticks_r   <= '0;
      sending_r <= 1'b0;
      line_r    <= 1'b1;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_wen) begin
        period_r <= cfg_wdata;
      end
      if (pop) begin
        shift_r   <= shift_nxt;
        idx_r     <= idx_nxt;
        ticks_r   <= ticks_nxt;
        sending_r <= sending_nxt;
        line_r    <= line_nxt;
        ovalid_r  <= 1'b1;
      end else if (out_tready) begin
        ovalid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ores_r <= {dropped, sending_nxt, line_nxt};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(OUT_W-3){1'b0}}, ores_r};

endmodule

>>> rtl/uart_tx_8n1_serializer_top.sv
// Top level of the 8N1 serial transmitter: front queue plus bit engine.
//
//   Channel  Dir  Handshake            Payload
//   in_      in   in_tvalid/in_tready  tdata[7:0] data_byte, tuser kind (0 tick, 1 load)
//   out_     out  out_tvalid/out_tready tdata[0] tx_line, [1] busy_res, [2] load_dropped
//   cfg_     in   cfg_wen              cfg_wdata[15:0] bit_period
//
// In steady state one word is taken per clock while out_tready is high, and each
// word yields exactly one result word. A word is held in the front queue and then
// in the back end's result register. The two-entry queue lets the front accept one
// more word while the result side stalls; when the queue fills, in_tready drops.
// Reset (rst_n low, synchronous) empties the queue and result stage, sets the line
// high and idle, and loads bit_period with 1666. Writes to bit_period take effect
// at the next clock edge.
module uart_tx_8n1_serializer_top #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input words.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [utx_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] data_byte
  input  logic                         in_tuser,   // [0] kind
  // Result words.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [utx_pkg::OUT_W-1:0]    out_tdata,  // [0] tx_line, [1] busy_res, [2] load_dropped
  // Bit period register.
  input  logic                         cfg_wen,
  input  logic [utx_pkg::PERIOD_W-1:0] cfg_wdata
);
  import utx_pkg::*;

  utx_head_t head;
  logic      pop;

  // The front end only classifies and buffers; all frame state lives behind it.
  utx_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  // While its result stage can take a result, the back end applies one word per cycle to
  // the frame state and registers the resulting line level, busy flag and drop flag.
  utx_back #(
    .DATA_BITS (DATA_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> test/uart_tx_8n1_serializer_top_test.sv
// Self-checking testbench for the 8N1 serial transmitter top level.
module uart_tx_8n1_serializer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utx_pkg::*;

  localparam int unsigned DATA_BITS = 8;
  localparam int unsigned USEFUL_TARGET = 600;

  // One expected result word. Packed with the line level in the lowest bit so that it
  // lines up with out_tdata: [0] tx_line, [1] busy_res, [2] load_dropped.
  typedef struct packed {
    logic dropped;
    logic busy;
    logic line;
  } line_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [BYTE_W-1:0]   in_tdata = '0;    // [7:0] data_byte
  logic                in_tuser = KIND_TICK;  // [0] kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;        // [0] tx_line, [1] busy_res, [2] load_dropped
  logic                cfg_wen = 1'b0;
  logic [PERIOD_W-1:0] cfg_wdata = '0;

  uart_tx_8n1_serializer_top #(.DATA_BITS(DATA_BITS)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)
  );

  // Our own copy of the transmitter: the bit period register and the frame state.
  logic [PERIOD_W-1:0] tx_period;
  logic [8:0]          tx_shift;
  logic [3:0]          tx_bit_idx;
  logic [PERIOD_W-1:0] tx_ticks;
  logic                tx_busy;
  logic                tx_level;

  // Expected result words, oldest first, and the run's bookkeeping.
  line_result_t expected_lines[$];
  int           mismatches = 0;
  int           useful_words = 0;
  logic         tx_gaps_on = 1'b1;
  logic         rx_stalls_on = 1'b1;
  logic         quiet_tail = 1'b0;
  int           rx_stall_left = 0;
  int           rx_cycle = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run.
  initial begin
    #2_000_000;
    $display("uart_tx_8n1_serializer_top: mismatch");
    $finish;
  end

  // Put the copy of the transmitter back into its reset state.
  task automatic reset_line_model();
    tx_period  = BIT_PERIOD_RST;
    tx_shift   = '0;
    tx_bit_idx = '0;
    tx_ticks   = '0;
    tx_busy    = 1'b0;
    tx_level   = 1'b1;
  endtask

  // Advance the copy of the transmitter by one word and return the result word it causes.
  // A load while idle drives the start bit at once; a load while busy is flagged and lost.
  // A tick while busy either counts up or, once the count has reached the period, moves
  // on to the next bit. The compare is ">=", so a period lowered mid-bit ends that bit on
  // the next tick instead of wrapping.
  function automatic line_result_t step_line(input logic kind, input logic [BYTE_W-1:0] data);
    line_result_t r;
    r.dropped = 1'b0;
    if (kind == KIND_LOAD) begin
      if (tx_busy) begin
        r.dropped = 1'b1;
      end else begin
        tx_shift   = {1'b0, data} & ((9'd1 << DATA_BITS) - 9'd1);
        tx_bit_idx = '0;
        tx_ticks   = '0;
        tx_busy    = 1'b1;
        tx_level   = 1'b0;
      end
    end else if (tx_busy) begin
      if (tx_ticks >= tx_period) begin
        tx_ticks   = '0;
        tx_bit_idx = tx_bit_idx + 4'd1;
        if (tx_bit_idx <= DATA_BITS) begin
          tx_level = tx_shift[0];
          tx_shift = tx_shift >> 1;
        end else if (tx_bit_idx == DATA_BITS + 1) begin
          tx_level = 1'b1;
        end else begin
          tx_busy    = 1'b0;
          tx_bit_idx = '0;
          tx_level   = 1'b1;
        end
      end else begin
        tx_ticks = tx_ticks + 1'b1;
      end
    end
    r.line = tx_level;
    r.busy = tx_busy;
    return r;
  endfunction

  // Offer one word and hold it until the block takes it. The valid stays high on return;
  // whoever idles the channel next lowers it, so it never drops and rises in one step.
  task automatic send_word(input logic kind, input logic [BYTE_W-1:0] data);
    logic ignored;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // Ticks while idle and loads while busy leave the frame alone.
    ignored = (kind == KIND_TICK && !tx_busy) || (kind == KIND_LOAD && tx_busy);
    expected_lines.push_back(step_line(kind, data));
    if (!ignored) useful_words++;
  endtask

  // Now and then leave the input channel empty for a short burst.
  task automatic maybe_pause();
    if (tx_gaps_on && !quiet_tail && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop offering words, let every expected word come back, then let the two-stage
  // pipeline run on so that nothing is still in flight.
  task automatic settle_line();
    in_tvalid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the bit period while the pipeline is empty. The write lands at the next edge,
  // before any further word can be taken.
  task automatic write_period(input logic [PERIOD_W-1:0] value);
    settle_line();
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    tx_period = value;
  endtask

  task automatic send_ticks(input int count);
    repeat (count) begin
      send_word(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
      maybe_pause();
    end
  endtask

  // Result side: random stall bursts, switched off for whole stretches, and never during
  // the quiet tail of the run.
  initial begin
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (rx_cycle % 256 == 0) rx_stalls_on = ($urandom_range(0, 3) != 0);
      if (rx_stall_left > 0 && !quiet_tail) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else if (rx_stalls_on && !quiet_tail && $urandom_range(0, 7) == 0) begin
        rx_stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %0b actual %0b", $time, name, want, got);
    end
  endfunction

  // Every result word taken is compared with the oldest expected word.
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_lines.size() == 0) begin
        mismatches++;
        $display("%0t: result word expected none actual %0h", $time, out_tdata);
      end else begin
        want = expected_lines.pop_front();
        check_field("tx_line", want.line, out_tdata[0]);
        check_field("busy_res", want.busy, out_tdata[1]);
        check_field("load_dropped", want.dropped, out_tdata[2]);
        if (out_tdata[OUT_W-1:3] !== '0) begin
          mismatches++;
          $display("%0t: tdata padding expected 0 actual %0h", $time, out_tdata[OUT_W-1:3]);
        end
      end
    end
  end

  // Reset period in force: a tick while idle, a frame start with an all-zero byte, a load
  // while busy with an all-ones byte that must be dropped, and the first ticks of the start bit.
  task automatic test_reset_default();
    send_word(KIND_TICK, 8'hFF);
    send_word(KIND_LOAD, 8'h00);
    send_word(KIND_LOAD, 8'hFF);
    send_ticks(2);
  endtask

  // Period changes in the middle of a frame, at both ends of the register. Dropping to 0
  // ends the start bit at once and makes every bit one tick long; a write of 65535 then
  // stretches a bit, and lowering to 1 below the count already reached ends it next tick.
  task automatic test_period_extremes();
    write_period('0);
    send_ticks(10);
    send_word(KIND_LOAD, 8'hFF);
    send_ticks(2);
    write_period('1);
    send_ticks(2);
    write_period(16'd1);
    send_ticks(2);
  endtask

  // Random phases, each with its own period, idling mix and stimulus shape. Most phases
  // send whole frames of random bytes; some throw in dropped loads and idle ticks, and a
  // few are plain noise.
  task automatic test_random_frames();
    int   pick;
    int   phase_words;
    logic noise;
    logic kind;
    logic [PERIOD_W-1:0] period;
    while (useful_words < USEFUL_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 13)       period = PERIOD_W'($urandom_range(1, 4));
      else if (pick < 15)  period = '0;
      else if (pick < 18)  period = PERIOD_W'($urandom_range(5, 30));
      else if (pick == 18) period = '1;
      else                 period = PERIOD_W'($urandom_range(100, 1666));
      write_period(period);
      tx_gaps_on  = ($urandom_range(0, 2) != 0);
      noise       = ($urandom_range(0, 4) == 0);
      phase_words = $urandom_range(40, 120);
      repeat (phase_words) begin
        if (noise)          kind = logic'($urandom_range(0, 1));
        else if (!tx_busy)  kind = ($urandom_range(0, 5) == 0) ? KIND_TICK : KIND_LOAD;
        else                kind = ($urandom_range(0, 24) == 0) ? KIND_LOAD : KIND_TICK;
        send_word(kind, BYTE_W'($urandom_range(0, 255)));
        maybe_pause();
      end
    end
  endtask

  // Last stretch with both sides running flat out: back-to-back frames, no gaps, no stalls.
  task automatic test_quiet_tail();
    write_period(16'd2);
    quiet_tail = 1'b1;
    repeat (120) begin
      send_word(tx_busy ? KIND_TICK : KIND_LOAD, BYTE_W'($urandom_range(0, 255)));
    end
    settle_line();
  endtask

  initial begin
    reset_line_model();
    // Synchronous reset, held low from the start and released on an edge.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_default();
    test_period_extremes();
    test_random_frames();
    test_quiet_tail();

    if (mismatches == 0) begin
      $display("uart_tx_8n1_serializer_top: match");
    end else begin
      $display("uart_tx_8n1_serializer_top: mismatch");
    end
    $finish;
  end

endmodule
